// File: sv/mm3_pkg.sv
// Shared types, constants and helper functions for the MurmurHash3 x64 128 stream hasher.
// No dependencies; every other file of the block imports this package.
package mm3_pkg;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 4;

    // Key and accumulator mixing constants
    localparam logic [WORD_W-1:0] MIX_C1  = 64'h87c3_7b91_1142_53d5;
    localparam logic [WORD_W-1:0] MIX_C2  = 64'h4cf5_ad43_2745_937f;
    localparam logic [WORD_W-1:0] ADD_ONE = 64'h0000_0000_52dc_e729;
    localparam logic [WORD_W-1:0] ADD_TWO = 64'h0000_0000_3849_5ab5;
    localparam logic [WORD_W-1:0] FIN_M1  = 64'hff51_afd7_ed55_8ccd;
    localparam logic [WORD_W-1:0] FIN_M2  = 64'hc4ce_b9fe_1a85_ec53;

    // Bytes in a full word
    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Command kinds
    localparam logic [1:0] CMD_BODY     = 2'd0;  // body block only
    localparam logic [1:0] CMD_BODY_FIN = 2'd1;  // body block, then finalize
    localparam logic [1:0] CMD_TAIL_FIN = 2'd2;  // tail fold, then finalize

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] key_one;   // word for the h1 lane
        logic [WORD_W-1:0] key_two;   // word for the h2 lane
        logic [WORD_W-1:0] length;    // message length, finalize only
    } mm3_cmd_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                 input int unsigned s);
        rotl64 = (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic logic [WORD_W-1:0] times_five(input logic [WORD_W-1:0] v);
        times_five = v + (v << 2);
    endfunction

    function automatic logic [WORD_W-1:0] fold_shift(input logic [WORD_W-1:0] v);
        fold_shift = v ^ (v >> 33);
    endfunction

endpackage

// File: sv/mm3_if.sv
// Valid/ready channel interfaces for the message input and the digest output.
// Depends on mm3_pkg for field widths.
interface mm3_msg_if;
    import mm3_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    data_word;
    logic [COUNT_W-1:0]   byte_count;
    logic                 last;

    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last,
                    output ready);
endinterface

interface mm3_digest_if;
    import mm3_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    hash_low;
    logic [WORD_W-1:0]    hash_high;

    modport source (output valid, output hash_low, output hash_high, input ready);
    modport sink   (input valid, input hash_low, input hash_high, output ready);
endinterface

// File: sv/mm3_mul.sv
// Shared 64 x 64 multiplier keeping the low 64 bits, split into 32-bit partial products.
// Partial products are registered; the product appears in the cycle after the operands.
// Depends on mm3_pkg.
module mm3_mul (
    input  logic                      clk,
    input  logic [mm3_pkg::WORD_W-1:0] a,
    input  logic [mm3_pkg::WORD_W-1:0] b,
    output logic [mm3_pkg::WORD_W-1:0] prod
);
    import mm3_pkg::*;

    localparam int HALF_W = WORD_W / 2;

    logic [WORD_W-1:0] low_pp_reg;
    logic [WORD_W-1:0] low_pp_next;
    logic [HALF_W-1:0] cross_reg;
    logic [HALF_W-1:0] cross_next;
    logic [HALF_W-1:0] cross_lh;
    logic [HALF_W-1:0] cross_hl;

    // Form partial products; cross terms only matter in their low half
    always_comb
    begin
        low_pp_next = WORD_W'(a[HALF_W-1:0]) * WORD_W'(b[HALF_W-1:0]);
        cross_lh    = a[HALF_W-1:0] * b[WORD_W-1:HALF_W];
        cross_hl    = a[WORD_W-1:HALF_W] * b[HALF_W-1:0];
        cross_next  = cross_lh + cross_hl;
    end

    always_ff @(posedge clk)
    begin
        low_pp_reg <= low_pp_next;
        cross_reg  <= cross_next;
    end

    // Combine partial products
    assign prod = low_pp_reg + {cross_reg, {HALF_W{1'b0}}};

endmodule

// File: sv/mm3_front.sv
// Front end: accepts message words, pairs them into blocks, masks the tail and
// tracks length, then issues commands to the queue. Depends on mm3_pkg, mm3_if.
module mm3_front (
    input  logic              clk,
    input  logic              rst_n,
    mm3_msg_if.sink           msg,
    input  logic              q_full,
    output logic              push,
    output mm3_pkg::mm3_cmd_t cmd
);
    import mm3_pkg::*;

    logic              half_reg;
    logic              half_next;
    logic [WORD_W-1:0] held_reg;
    logic [WORD_W-1:0] held_next;
    logic [WORD_W-1:0] total_reg;
    logic [WORD_W-1:0] total_next;
    logic [COUNT_W-1:0] count_sat;
    logic [WORD_W-1:0] masked;
    logic              accept;

    assign msg.ready = !q_full;
    assign accept    = msg.valid && msg.ready;

    // Clamp the count and drop unused high bytes
    always_comb
    begin
        count_sat = (msg.byte_count > FULL_COUNT) ? FULL_COUNT : msg.byte_count;
        for (int i = 0; i < WORD_W / 8; i++)
        begin
            masked[8*i +: 8] = (COUNT_W'(i) < count_sat) ? msg.data_word[8*i +: 8] : 8'h00;
        end
    end

    // Classify the transfer and build the command
    always_comb
    begin
        half_next   = half_reg;
        held_next   = held_reg;
        total_next  = total_reg;
        push        = 1'b0;
        cmd.kind    = CMD_BODY;
        cmd.key_one = held_reg;
        cmd.key_two = msg.data_word;
        cmd.length  = total_reg;
        if (accept)
        begin
            if (!msg.last)
            begin
                total_next = total_reg + WORD_W'(FULL_COUNT);
                if (half_reg)
                begin
                    push      = 1'b1;
                    half_next = 1'b0;
                end
                else
                begin
                    held_next = msg.data_word;
                    half_next = 1'b1;
                end
            end
            else
            begin
                push       = 1'b1;
                cmd.length = total_reg + WORD_W'(count_sat);
                if (half_reg && count_sat == FULL_COUNT)
                begin
                    cmd.kind    = CMD_BODY_FIN;
                    cmd.key_one = held_reg;
                    cmd.key_two = masked;
                end
                else
                begin
                    cmd.kind    = CMD_TAIL_FIN;
                    cmd.key_one = half_reg ? held_reg : masked;
                    cmd.key_two = half_reg ? masked : '0;
                end
                half_next  = 1'b0;
                held_next  = '0;
                total_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            half_reg  <= half_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

// File: sv/mm3_queue.sv
// Short command queue that decouples the front end from the mixing sequencer.
// Depends on mm3_pkg.
module mm3_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mm3_pkg::mm3_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output mm3_pkg::mm3_cmd_t q_cmd
);
    import mm3_pkg::*;

    mm3_cmd_t           entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/mm3_back.sv
// Back end: sequencer that runs key mixing, the h1/h2 block update and the
// finalizer on one shared multiplier, and holds the digest output register.
// Depends on mm3_pkg, mm3_if, mm3_mul.
module mm3_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  mm3_pkg::mm3_cmd_t q_cmd,
    output logic              pop,
    mm3_digest_if.source      digest
);
    import mm3_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_L0   = 4'd1;   // issue key_one * C1
    localparam logic [3:0] ST_L1   = 4'd2;   // issue key_two * C2
    localparam logic [3:0] ST_L2   = 4'd3;   // issue lane one second multiply
    localparam logic [3:0] ST_L3   = 4'd4;   // issue lane two second multiply
    localparam logic [3:0] ST_L4   = 4'd5;   // collect lane two
    localparam logic [3:0] ST_H1   = 4'd6;   // update h1
    localparam logic [3:0] ST_H2   = 4'd7;   // update h2
    localparam logic [3:0] ST_F0   = 4'd8;   // length fold and cross add
    localparam logic [3:0] ST_F1   = 4'd9;
    localparam logic [3:0] ST_F2   = 4'd10;
    localparam logic [3:0] ST_F3   = 4'd11;
    localparam logic [3:0] ST_F4   = 4'd12;
    localparam logic [3:0] ST_F5   = 4'd13;
    localparam logic [3:0] ST_F6   = 4'd14;  // final cross add, hand to output

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [WORD_W-1:0] acc1_reg;
    logic [WORD_W-1:0] acc1_next;
    logic [WORD_W-1:0] acc2_reg;
    logic [WORD_W-1:0] acc2_next;
    logic [WORD_W-1:0] tmp1_reg;
    logic [WORD_W-1:0] tmp1_next;
    logic [WORD_W-1:0] tmp2_reg;
    logic [WORD_W-1:0] tmp2_next;
    mm3_cmd_t          cmd_reg;
    mm3_cmd_t          cmd_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] hash_low_reg;
    logic [WORD_W-1:0] hash_low_next;
    logic [WORD_W-1:0] hash_high_reg;
    logic [WORD_W-1:0] hash_high_next;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic [WORD_W-1:0] prod;
    logic [WORD_W-1:0] len_one;
    logic [WORD_W-1:0] len_two;
    logic [WORD_W-1:0] sum_one;
    logic              out_free;

    mm3_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign out_free         = !out_valid_reg || digest.ready;
    assign digest.valid     = out_valid_reg;
    assign digest.hash_low  = hash_low_reg;
    assign digest.hash_high = hash_high_reg;
    assign pop              = (state_reg == ST_IDLE) && q_valid;

    // Select multiplier operands for the current step
    always_comb
    begin
        unique case (state_reg)
            ST_L0:   begin mul_a = cmd_reg.key_one;      mul_b = MIX_C1; end
            ST_L1:   begin mul_a = cmd_reg.key_two;      mul_b = MIX_C2; end
            ST_L2:   begin mul_a = tmp1_reg;             mul_b = MIX_C2; end
            ST_L3:   begin mul_a = tmp2_reg;             mul_b = MIX_C1; end
            ST_F1:   begin mul_a = fold_shift(acc1_reg); mul_b = FIN_M1; end
            ST_F2:   begin mul_a = fold_shift(acc2_reg); mul_b = FIN_M1; end
            ST_F3:   begin mul_a = acc1_reg;             mul_b = FIN_M2; end
            ST_F4:   begin mul_a = acc2_reg;             mul_b = FIN_M2; end
            default: begin mul_a = '0;                   mul_b = '0;     end
        endcase
    end

    // Step the sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc1_next      = acc1_reg;
        acc2_next      = acc2_reg;
        tmp1_next      = tmp1_reg;
        tmp2_next      = tmp2_reg;
        cmd_next       = cmd_reg;
        hash_low_next  = hash_low_reg;
        hash_high_next = hash_high_reg;
        out_valid_next = out_valid_reg && !digest.ready;
        len_one        = acc1_reg ^ cmd_reg.length;
        len_two        = acc2_reg ^ cmd_reg.length;
        sum_one        = acc1_reg + acc2_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next   = q_cmd;
                    state_next = ST_L0;
                end
            end
            ST_L0:
            begin
                state_next = ST_L1;
            end
            ST_L1:
            begin
                tmp1_next  = rotl64(prod, 31);
                state_next = ST_L2;
            end
            ST_L2:
            begin
                tmp2_next  = rotl64(prod, 33);
                state_next = ST_L3;
            end
            ST_L3:
            begin
                tmp1_next  = prod;
                state_next = ST_L4;
            end
            ST_L4:
            begin
                if (cmd_reg.kind == CMD_TAIL_FIN)
                begin
                    acc1_next  = acc1_reg ^ tmp1_reg;
                    acc2_next  = acc2_reg ^ prod;
                    state_next = ST_F0;
                end
                else
                begin
                    tmp2_next  = prod;
                    state_next = ST_H1;
                end
            end
            ST_H1:
            begin
                acc1_next  = times_five(rotl64(acc1_reg ^ tmp1_reg, 27) + acc2_reg) + ADD_ONE;
                state_next = ST_H2;
            end
            ST_H2:
            begin
                acc2_next  = times_five(rotl64(acc2_reg ^ tmp2_reg, 31) + acc1_reg) + ADD_TWO;
                state_next = (cmd_reg.kind == CMD_BODY_FIN) ? ST_F0 : ST_IDLE;
            end
            ST_F0:
            begin
                acc1_next  = len_one + len_two;
                acc2_next  = len_two + (len_one + len_two);
                state_next = ST_F1;
            end
            ST_F1:
            begin
                state_next = ST_F2;
            end
            ST_F2:
            begin
                acc1_next  = fold_shift(prod);
                state_next = ST_F3;
            end
            ST_F3:
            begin
                acc2_next  = fold_shift(prod);
                state_next = ST_F4;
            end
            ST_F4:
            begin
                acc1_next  = fold_shift(prod);
                state_next = ST_F5;
            end
            ST_F5:
            begin
                acc2_next  = fold_shift(prod);
                state_next = ST_F6;
            end
            ST_F6:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    hash_low_next  = sum_one;
                    hash_high_next = acc2_reg + sum_one;
                    out_valid_next = 1'b1;
                    acc1_next      = '0;
                    acc2_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc1_reg      <= '0;
            acc2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc1_reg      <= acc1_next;
            acc2_reg      <= acc2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp1_reg      <= tmp1_next;
        tmp2_reg      <= tmp2_next;
        cmd_reg       <= cmd_next;
        hash_low_reg  <= hash_low_next;
        hash_high_reg <= hash_high_next;
    end

endmodule

// File: sv/murmur3_128_stream_hash.sv
// Top level of the MurmurHash3 x64 128-bit stream hasher (seed zero).
// Depends on mm3_pkg, mm3_if, mm3_front, mm3_queue, mm3_back.
//
//   channel | dir | fields                          | transfer
//   --------+-----+---------------------------------+-------------------------
//   msg     | in  | data_word, byte_count, last     | valid & ready, per word
//   digest  | out | hash_low, hash_high             | valid & ready, per message
//
// The front takes one word per cycle while its two-entry command queue has room.
// Each word pair is a pop, key mixing on the shared 64-bit multiplier and the
// h1/h2 update in the sequencer; a last word runs tail fold and finalize, or the
// block update and finalize when it closes a full block, plus any digest stall.
// The shared multiplier sets the sustained rate; the sequencer pops only when idle.
// rst_n clears control state asynchronously; the digest register holds a result
// until taken, and a full queue stalls msg.ready.
module murmur3_128_stream_hash (
    input  logic          clk,
    input  logic          rst_n,
    mm3_msg_if.sink       msg,
    mm3_digest_if.source  digest
);
    import mm3_pkg::*;

    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     pop;
    mm3_cmd_t push_cmd;
    mm3_cmd_t q_cmd;

    mm3_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .q_full (q_full),
        .push   (push),
        .cmd    (push_cmd)
    );

    mm3_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    mm3_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop),
        .digest  (digest)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for murmur3_128_stream_hash: drives whole messages over the
// msg channel, predicts each 128-bit digest, and checks it on the digest channel.
// Depends on mm3_pkg, mm3_if and murmur3_128_stream_hash from the RTL.
module tb_top;
    import mm3_pkg::*;

    // Hash constants for the digest predictor
    localparam logic [63:0] KEY_C1   = 64'h87c3_7b91_1142_53d5;
    localparam logic [63:0] KEY_C2   = 64'h4cf5_ad43_2745_937f;
    localparam logic [63:0] H1_ADD   = 64'h0000_0000_52dc_e729;
    localparam logic [63:0] H2_ADD   = 64'h0000_0000_3849_5ab5;
    localparam logic [63:0] FMIX_A   = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] FMIX_B   = 64'hc4ce_b9fe_1a85_ec53;
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    localparam int STALL_LIMIT = 1000;  // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES = 60;   // settle time once every digest has arrived

    typedef struct packed {
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] high;
    } digest_t;

    logic clk;
    logic rst_n;

    mm3_msg_if    msg_ch ();
    mm3_digest_if dig_ch ();

    murmur3_128_stream_hash uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    // Predictor state: running h1/h2, pending first word of a block, byte length
    logic [63:0] run_h1;
    logic [63:0] run_h2;
    logic [63:0] held_key;
    logic        key_held;
    logic [63:0] msg_len;

    digest_t expected_digests[$];
    int      error_count = 0;
    int      words_sent = 0;
    int      idle_cycles = 0;
    int      stall_left = 0;
    bit      idling = 1'b1;

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] rot_l(input logic [63:0] v, input int s);
        return (v << s) | (v >> (64 - s));
    endfunction

    function automatic logic [63:0] lane_one_key(input logic [63:0] k);
        logic [63:0] t;
        t = k * KEY_C1;
        t = rot_l(t, 31);
        return t * KEY_C2;
    endfunction

    function automatic logic [63:0] lane_two_key(input logic [63:0] k);
        logic [63:0] t;
        t = k * KEY_C2;
        t = rot_l(t, 33);
        return t * KEY_C1;
    endfunction

    function automatic logic [63:0] fmix(input logic [63:0] k);
        logic [63:0] t;
        t = k ^ (k >> 33);
        t = t * FMIX_A;
        t = t ^ (t >> 33);
        t = t * FMIX_B;
        return t ^ (t >> 33);
    endfunction

    // Fold one 16-byte body block into h1 and h2
    function automatic void mix_block(input logic [63:0] w1, input logic [63:0] w2);
        run_h1 = run_h1 ^ lane_one_key(w1);
        run_h1 = rot_l(run_h1, 27);
        run_h1 = run_h1 + run_h2;
        run_h1 = run_h1 * 64'd5 + H1_ADD;
        run_h2 = run_h2 ^ lane_two_key(w2);
        run_h2 = rot_l(run_h2, 31);
        run_h2 = run_h2 + run_h1;
        run_h2 = run_h2 * 64'd5 + H2_ADD;
    endfunction

    function automatic void clear_hash_state();
        run_h1 = '0;
        run_h2 = '0;
        held_key = '0;
        key_held = 1'b0;
        msg_len = '0;
    endfunction

    // Absorb one accepted word; on the last word, queue the predicted digest
    function automatic void absorb_word(input logic [63:0] word, input logic [3:0] count,
                                        input logic last);
        logic [3:0]  n;
        logic [63:0] w;
        logic [63:0] h1;
        logic [63:0] h2;
        digest_t     d;
        if (!last)
        begin
            msg_len = msg_len + 64'd8;
            if (key_held)
            begin
                mix_block(held_key, word);
                key_held = 1'b0;
            end
            else
            begin
                held_key = word;
                key_held = 1'b1;
            end
            return;
        end
        // Clamp oversize counts and drop bytes above the count
        n = (count > 4'd8) ? 4'd8 : count;
        w = (n == 4'd8) ? word : (word & ((64'd1 << (8 * n)) - 64'd1));
        msg_len = msg_len + {60'd0, n};
        if (key_held)
        begin
            if (n == 4'd8)
                mix_block(held_key, w);
            else
            begin
                if (n != 4'd0)
                    run_h2 = run_h2 ^ lane_two_key(w);
                run_h1 = run_h1 ^ lane_one_key(held_key);
            end
        end
        else if (n != 4'd0)
            run_h1 = run_h1 ^ lane_one_key(w);
        // Finalize
        h1 = run_h1 ^ msg_len;
        h2 = run_h2 ^ msg_len;
        h1 = h1 + h2;
        h2 = h2 + h1;
        h1 = fmix(h1);
        h2 = fmix(h2);
        h1 = h1 + h2;
        h2 = h2 + h1;
        d.low = h1;
        d.high = h2;
        expected_digests = {expected_digests, d};
        clear_hash_state();
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Send one word; returns at the rising edge of its transfer
    task automatic send_word(input logic [63:0] word, input logic [3:0] count, input logic last);
        int gap;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        msg_ch.valid <= 1'b1;
        msg_ch.data_word <= word;
        msg_ch.byte_count <= count;
        msg_ch.last <= last;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        absorb_word(word, count, last);
        words_sent++;
    endtask

    // Send a message of body words plus a last word; noisy bodies carry odd counts
    task automatic send_message(input int body_words, input bit noisy);
        logic [3:0] count;
        for (int i = 0; i < body_words; i++)
        begin
            if (noisy && $urandom_range(0, 2) == 0)
                count = 4'($urandom_range(0, 15));
            else
                count = FULL_COUNT;
            send_word(rand_word(), count, 1'b0);
        end
        if ($urandom_range(0, 5) == 0)
            count = 4'($urandom_range(9, 15));
        else
            count = 4'($urandom_range(0, 8));
        send_word(rand_word(), count, 1'b1);
    endtask

    // Hold off the sender until every digest has come back
    task automatic wait_for_digests();
        @(negedge clk);
        msg_ch.valid <= 1'b0;
        while (expected_digests.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        // Empty message, full single word, oversize count, partial word with junk
        send_word(ALL_ONES, 4'd0, 1'b1);
        send_word(ALL_ONES, 4'd8, 1'b1);
        send_word(64'd0, 4'd15, 1'b1);
        send_word(ALL_ONES, 4'd3, 1'b1);
        // Held word closed by a full last word
        send_word(ALL_ONES, 4'd0, 1'b0);
        send_word(64'd0, 4'd8, 1'b1);
        // Held word closed by an empty last word; short count ignored on body word
        send_word(ALL_ONES, 4'd5, 1'b0);
        send_word(ALL_ONES, 4'd0, 1'b1);
        // Full block, then a partial word with nothing held
        send_word(64'd0, FULL_COUNT, 1'b0);
        send_word(ALL_ONES, FULL_COUNT, 1'b0);
        send_word(ALL_ONES, 4'd4, 1'b1);
        // Block plus held word plus a seven-byte tail
        send_word(64'h0123_4567_89ab_cdef, FULL_COUNT, 1'b0);
        send_word(64'hfedc_ba98_7654_3210, FULL_COUNT, 1'b0);
        send_word(64'h8000_0000_0000_0001, FULL_COUNT, 1'b0);
        send_word(ALL_ONES, 4'd7, 1'b1);
        // Held word with an oversize last count
        send_word(64'h5555_aaaa_5555_aaaa, 4'd9, 1'b0);
        send_word(64'haaaa_5555_aaaa_5555, 4'd12, 1'b1);
        // One-byte messages
        send_word(64'hffff_ffff_ffff_ff80, 4'd1, 1'b1);
        send_word(64'h0000_0000_0000_0001, 4'd1, 1'b1);
        wait_for_digests();
    endtask

    task automatic test_random_messages(input int target);
        int start;
        int body_words;
        start = words_sent;
        while (words_sent - start < target)
        begin
            // Switch idling on and off now and then for stretches without gaps
            if ($urandom_range(0, 19) == 0)
                idling = !idling;
            if ($urandom_range(0, 9) == 0)
                body_words = $urandom_range(8, 40);
            else
                body_words = $urandom_range(0, 6);
            send_message(body_words, $urandom_range(0, 6) == 0);
        end
        idling = 1'b1;
    endtask

    task automatic test_drain_pauses();
        repeat (6)
        begin
            send_message($urandom_range(0, 5), 1'b0);
            wait_for_digests();
        end
    endtask

    task automatic test_steady_stream(input int target);
        int start;
        idling = 1'b0;
        start = words_sent;
        while (words_sent - start < target)
            send_message($urandom_range(0, 8), 1'b0);
    endtask

    // Receiver: ready with random stall bursts while idling
    always @(negedge clk)
    begin
        if (!rst_n)
            dig_ch.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            dig_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            dig_ch.ready <= 1'b0;
        end
        else
            dig_ch.ready <= 1'b1;
    end

    // Check each digest transfer against the oldest prediction
    always @(posedge clk)
    begin
        digest_t want;
        if (rst_n && dig_ch.valid && dig_ch.ready)
        begin
            if (expected_digests.size() == 0)
            begin
                $display("%0t: unexpected digest, expected none actual %h %h",
                         $realtime, dig_ch.hash_high, dig_ch.hash_low);
                error_count++;
            end
            else
            begin
                want = expected_digests.pop_front();
                if (dig_ch.hash_low !== want.low)
                begin
                    $display("%0t: hash_low expected %h actual %h",
                             $realtime, want.low, dig_ch.hash_low);
                    error_count++;
                end
                if (dig_ch.hash_high !== want.high)
                begin
                    $display("%0t: hash_high expected %h actual %h",
                             $realtime, want.high, dig_ch.hash_high);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        msg_ch.valid = 1'b0;
        msg_ch.data_word = '0;
        msg_ch.byte_count = '0;
        msg_ch.last = 1'b0;
        dig_ch.ready = 1'b0;
        clear_hash_state();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_messages(1400);
        test_drain_pauses();
        test_steady_stream(300);

        // Drain and let any stray digest show up
        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: files.f
sv/mm3_pkg.sv
sv/mm3_if.sv
sv/mm3_mul.sv
sv/mm3_front.sv
sv/mm3_queue.sv
sv/mm3_back.sv
sv/murmur3_128_stream_hash.sv
dv/tb_top.sv
